@@ hdl/assert_macros.svh @@
// Assertion macros shared by the slab block size select RTL.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check
`define SBSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check
`define SBSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sbss_pkg.sv @@
// Package for the slab block size select block: sizes, codes and the
// command and status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package sbss_pkg;

    localparam int LOG_PAGE_SIZE    = 12;
    localparam int MAX_PAGES        = 32;
    localparam int BITMAP_WORD_BITS = 32;
    localparam int WASTE_SHIFT      = 3;

    // Field widths
    localparam int SLICE_W = 16;
    localparam int PAGE_W  = 6;
    localparam int BYTES_W = 18;
    localparam int CNT_W   = 18;
    localparam int WORDS_W = 13;

    // Internal widths
    localparam int BLK_W      = PAGE_W + LOG_PAGE_SIZE;
    localparam int DVD_W      = BLK_W + 1;
    localparam int DVS_W      = SLICE_W;
    localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
    localparam int PAGE_BYTES = 1 << LOG_PAGE_SIZE;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAGE_DIV,
        S_PAGE_WAIT,
        S_TRIAL,
        S_CLAMP,
        S_COUNT_DIV,
        S_COUNT_WAIT,
        S_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_PAGE,
        DIV_COUNT
    } div_sel_t;

    typedef struct packed {
        logic     take_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     trial_init;
        logic     trial_step;
        logic     clamp;
        logic     count_load;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic trial_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/slab_block_size_select.sv @@
// Top level of the slab block size select block: controller plus datapath.
// Depends on sbss_pkg, sbss_ctrl, sbss_dpath (and sbss_div below it).
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  input    | in_valid, in_ready  | slice_size, restart_table
//  output   | out_valid, out_ready| page_count, block_bytes, slices_per_block,
//           |                     | bitmap_words
//
// One request at a time: a new request is accepted only in the idle state, once the
// previous result has been loaded into the output register; T = 1..MAX_PAGES trial steps.
// The shared bit-serial divider (DVD_W = 19 steps) is run twice per request.
// Reset (rst_n low, asynchronous) clears the previous page count and the control.
// A result waits in the output register; the next request is taken meanwhile and
// stalls only at its own result stage until the register is free.
`timescale 1ns / 1ps

module slab_block_size_select (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sbss_pkg::SLICE_W-1:0] slice_size,
    input  logic                         restart_table,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sbss_pkg::PAGE_W-1:0]  page_count,
    output logic [sbss_pkg::BYTES_W-1:0] block_bytes,
    output logic [sbss_pkg::CNT_W-1:0]   slices_per_block,
    output logic [sbss_pkg::WORDS_W-1:0] bitmap_words
);
    import sbss_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sbss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sbss_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .slice_size       (slice_size),
        .restart_table    (restart_table),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .page_count       (page_count),
        .block_bytes      (block_bytes),
        .slices_per_block (slices_per_block),
        .bitmap_words     (bitmap_words)
    );

endmodule

@@ hdl/sbss_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on sbss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbss_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sbss_pkg::DVD_W-1:0] dividend,
    input  logic [sbss_pkg::DVS_W-1:0] divisor,
    output logic                       done,
    output logic [sbss_pkg::DVD_W-1:0] quotient,
    output logic [sbss_pkg::DVS_W-1:0] remainder
);
    import sbss_pkg::*;

    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 ge;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // Load on start, then shift one bit per cycle
    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = DIV_CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

    `SBSS_ASSERT_IMP(a_start_when_idle, start, cnt_reg == '0, "divider restarted while busy")
    `SBSS_ASSERT_IMP(a_rem_below_divisor, done_reg, rem_reg < dvs_reg, "remainder not reduced")

endmodule

@@ hdl/sbss_dpath.sv @@
// Datapath: input and result registers, trial-remainder scan, clamp and
// divider operand selection. Depends on sbss_pkg, sbss_div, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbss_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbss_pkg::dp_cmd_t            cmd,
    output sbss_pkg::dp_status_t         status,
    input  logic [sbss_pkg::SLICE_W-1:0] slice_size,
    input  logic                         restart_table,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [sbss_pkg::PAGE_W-1:0]  page_count,
    output logic [sbss_pkg::BYTES_W-1:0] block_bytes,
    output logic [sbss_pkg::CNT_W-1:0]   slices_per_block,
    output logic [sbss_pkg::WORDS_W-1:0] bitmap_words
);
    import sbss_pkg::*;

    // Request and scan registers
    logic [SLICE_W-1:0] slice_reg;
    logic               restart_reg;
    logic [PAGE_W-1:0]  prev_reg, prev_next;
    logic [PAGE_W-1:0]  n_reg;
    logic [BLK_W-1:0]   tblk_reg;
    logic [SLICE_W-1:0] prem_reg;
    logic [SLICE_W-1:0] acc_reg;
    logic [SLICE_W-1:0] best_reg;
    logic               have_best_reg;
    logic [PAGE_W-1:0]  pick_reg;
    logic [PAGE_W-1:0]  pages_reg;
    logic [DVD_W-1:0]   blk_reg;
    logic [DVD_W-1:0]   count_reg;

    // Result registers
    logic               out_valid_reg, out_valid_next;
    logic [PAGE_W-1:0]  page_out_reg;
    logic [BYTES_W-1:0] bytes_out_reg;
    logic [CNT_W-1:0]   cnt_out_reg;
    logic [WORDS_W-1:0] words_out_reg;

    // Divider hookup
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic [DVS_W-1:0]   div_r;

    // Scan and clamp logic
    logic               fits;
    logic               good;
    logic               found;
    logic [SLICE_W:0]   acc_sum;
    logic [SLICE_W-1:0] acc_step;
    logic [DVD_W-1:0]   ceil_sum;
    logic [PAGE_W-1:0]  ceil_pages;
    logic [PAGE_W-1:0]  prev_eff;
    logic [PAGE_W-1:0]  pages_clamped;
    logic [DVD_W-1:0]   words_sum;
    logic [WORDS_W-1:0] words_calc;

    sbss_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Pick divider operands
    always_comb
    begin
        case (cmd.div_sel)
            DIV_COUNT:
            begin
                div_dvd = blk_reg;
                div_dvs = slice_reg;
            end
            default:
            begin
                div_dvd = DVD_W'(PAGE_BYTES);
                div_dvs = slice_reg;
            end
        endcase
    end

    // Evaluate the current trial block and advance its remainder
    always_comb
    begin
        fits     = (tblk_reg >= BLK_W'(slice_reg));
        good     = (BLK_W'(acc_reg) <= (tblk_reg >> WASTE_SHIFT));
        found    = fits && good;
        acc_sum  = {1'b0, acc_reg} + {1'b0, prem_reg};
        if (acc_sum >= {1'b0, slice_reg})
            acc_step = SLICE_W'(acc_sum - {1'b0, slice_reg});
        else
            acc_step = acc_sum[SLICE_W-1:0];
        ceil_sum   = DVD_W'(slice_reg) + DVD_W'(PAGE_BYTES - 1);
        ceil_pages = PAGE_W'(ceil_sum >> LOG_PAGE_SIZE);
    end

    // Round the slice count up to whole bitmap words (power-of-two word size)
    always_comb
    begin
        words_sum  = count_reg + DVD_W'(BITMAP_WORD_BITS - 1);
        words_calc = WORDS_W'(words_sum / DVD_W'(BITMAP_WORD_BITS));
    end

    // Clamp against the previous class
    always_comb
    begin
        prev_eff = restart_reg ? '0 : prev_reg;
        if (prev_eff != '0 && pick_reg < prev_eff)
            pages_clamped = prev_eff;
        else
            pages_clamped = pick_reg;
        prev_next = prev_reg;
        if (cmd.clamp)
            prev_next = pages_clamped;
    end

    // Hold a result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            slice_reg   <= (slice_size == '0) ? SLICE_W'(1) : slice_size;
            restart_reg <= restart_table;
        end
        if (cmd.trial_init)
        begin
            prem_reg      <= div_r;
            acc_reg       <= div_r;
            n_reg         <= PAGE_W'(1);
            tblk_reg      <= BLK_W'(PAGE_BYTES);
            have_best_reg <= 1'b0;
            pick_reg      <= ceil_pages;
        end
        if (cmd.trial_step)
        begin
            acc_reg  <= acc_step;
            n_reg    <= n_reg + 1'b1;
            tblk_reg <= tblk_reg + BLK_W'(PAGE_BYTES);
            if (found)
                pick_reg <= n_reg;
            else if (fits && (!have_best_reg || acc_reg < best_reg))
            begin
                have_best_reg <= 1'b1;
                best_reg      <= acc_reg;
                pick_reg      <= n_reg;
            end
        end
        if (cmd.clamp)
        begin
            pages_reg <= pages_clamped;
            blk_reg   <= DVD_W'(pages_clamped) << LOG_PAGE_SIZE;
        end
        if (cmd.count_load)
            count_reg <= div_q;
        if (cmd.out_load)
        begin
            page_out_reg  <= pages_reg;
            bytes_out_reg <= blk_reg[BYTES_W-1:0];
            cnt_out_reg   <= count_reg[CNT_W-1:0];
            words_out_reg <= words_calc;
        end
    end

    assign status.div_done   = div_done;
    assign status.trial_last = found || (n_reg == PAGE_W'(MAX_PAGES));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign page_count       = page_out_reg;
    assign block_bytes      = bytes_out_reg;
    assign slices_per_block = cnt_out_reg;
    assign bitmap_words     = words_out_reg;

    `SBSS_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready, "result overwritten")
    `SBSS_ASSERT_NXT(a_clamp_monotonic, cmd.clamp && !restart_reg && prev_reg != '0, pages_reg >= $past(prev_reg), "page count fell below previous class")

endmodule

@@ hdl/sbss_ctrl.sv @@
// Controller state machine: sequences input capture, the page-mod division,
// the trial scan, the clamp and the slice count division. Depends on sbss_pkg.
`timescale 1ns / 1ps

module sbss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sbss_pkg::dp_status_t status,
    output sbss_pkg::dp_cmd_t    cmd
);
    import sbss_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (in_valid) state_next = S_PAGE_DIV;
            S_PAGE_DIV:   state_next = S_PAGE_WAIT;
            S_PAGE_WAIT:  if (status.div_done) state_next = S_TRIAL;
            S_TRIAL:      if (status.trial_last) state_next = S_CLAMP;
            S_CLAMP:      state_next = S_COUNT_DIV;
            S_COUNT_DIV:  state_next = S_COUNT_WAIT;
            S_COUNT_WAIT: if (status.div_done) state_next = S_OUT;
            S_OUT:        if (status.out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.take_in = in_valid;
            end
            S_PAGE_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PAGE;
            end
            S_PAGE_WAIT:  cmd.trial_init = status.div_done;
            S_TRIAL:      cmd.trial_step = 1'b1;
            S_CLAMP:      cmd.clamp = 1'b1;
            S_COUNT_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_COUNT;
            end
            S_COUNT_WAIT: cmd.count_load = status.div_done;
            S_OUT:        cmd.out_load = status.out_free;
            default:      cmd = '0;
        endcase
    end

endmodule
